/* rtl/core/tpi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_pkg
// shared types, codes and sizes of the timestamped pose interpolator
// ----------------------------------------------------------------------------
package tpi_pkg;

    localparam int unsigned HISTORY_DEPTH = 64;
    localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH);
    localparam int unsigned CNT_W = IDX_W + 1;

    localparam int unsigned ACC_W     = 66;
    localparam int unsigned QUO_W     = 65;
    localparam int unsigned MUL_STEPS = 32;
    localparam int unsigned STEP_W    = 7;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam logic [1:0] FUNC_PUSH   = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_LATEST = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_FEW    = 3'd1;
    localparam logic [2:0] ST_RANGE      = 3'd2;
    localparam logic [2:0] ST_EXTRAP_GAP = 3'd3;
    localparam logic [2:0] ST_BEFORE     = 3'd4;
    localparam logic [2:0] ST_INTERP_GAP = 3'd5;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_XGAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IGAP   = 3'd4;

    typedef struct packed {
        logic        [31:0] stamp;
        logic signed [31:0] yaw;
        logic signed [15:0] pitch;
    } t_entry;

    typedef enum logic [1:0] {
        OP_MUL_NEW,
        OP_MUL_ACC,
        OP_DIV
    } t_mdu_op;

    typedef struct packed {
        logic               start;
        t_mdu_op            op;
        logic signed [33:0] mul_a;
        logic        [31:0] mul_b;
        logic        [31:0] divisor;
    } t_mdu_req;

    typedef struct packed {
        logic             done;
        logic             neg;
        logic [QUO_W-1:0] quo;
    } t_mdu_rsp;

endpackage

/* rtl/core/tpi_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_in_if
// command channel: push, query, latest read, clear
// ----------------------------------------------------------------------------
interface tpi_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  func;
    logic        [31:0] stamp_us;
    logic signed [31:0] yaw_in;
    logic signed [15:0] pitch_in;

    modport source (output valid, func, stamp_us, yaw_in, pitch_in, input ready);
    modport sink   (input valid, func, stamp_us, yaw_in, pitch_in, output ready);
endinterface

/* rtl/core/tpi_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_out_if
// result channel: status and pose
// ----------------------------------------------------------------------------
interface tpi_out_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  status;
    logic signed [31:0] yaw_out;
    logic signed [15:0] pitch_out;

    modport source (output valid, status, yaw_out, pitch_out, input ready);
    modport sink   (input valid, status, yaw_out, pitch_out, output ready);
endinterface

/* rtl/core/tpi_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface tpi_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/timestamped_pose_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_pose_interpolator
// ring of timestamped gimbal poses with interpolated lookup by time
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one command a beat: push a pose, query a time, read the
//   latest pose, or clear. query and latest read give one beat on o_out;
//   push and clear give none. i_cfg writes the five limit registers and is
//   always ready; write it only while the block is idle.
// sequence (one command at a time, i_in.ready is low while busy):
//   push: the oldest entry is read and window-checked, again after each
//   dropped stale entry; no check after a push into an empty ring
//   latest read: reads the newest entry, or none when the ring is empty
//   query: walks back, reading then checking each history entry (one read
//   port), then the shared bit-serial multiply/divide unit runs a yaw
//   multiply, a yaw divide, two pitch multiplies and a pitch divide
//   failed queries answer right after the check that fails
// reset: ring empty, limits at their defaults; no clearing pass is needed,
//   entries are never read before they are written
// stall: a result waits in its output register until o_out.ready; no new
//   command is taken until it leaves
// ----------------------------------------------------------------------------
module timestamped_pose_interpolator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpi_in_if.sink    i_in,
    tpi_cfg_if.sink   i_cfg,
    tpi_out_if.source o_out
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DRD   = 12'b000000000010,  // read oldest entry for window check
        S_DCHK  = 12'b000000000100,
        S_QRD   = 12'b000000001000,  // read entry during backward search or latest read
        S_QCHK  = 12'b000000010000,
        S_SETUP = 12'b000000100000,  // gap checks and operand capture
        S_YMUL  = 12'b000001000000,
        S_YDIV  = 12'b000010000000,
        S_PMUL0 = 12'b000100000000,
        S_PMUL1 = 12'b001000000000,
        S_PDIV  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    // limit registers
    logic [31:0] r_window, r_lead, r_lag, r_xgap, r_igap;

    // ring pointers
    tpi_pkg::t_idx r_oldest, n_oldest;
    tpi_pkg::t_cnt r_count, n_count;
    logic [31:0]   r_newest, n_newest;

    // command context
    logic [31:0]        r_t, n_t;
    logic               r_extrap, n_extrap;
    logic               r_latest, n_latest;
    logic               r_first, n_first;
    tpi_pkg::t_idx      r_r, n_r;
    tpi_pkg::t_entry    r_prev, n_prev;
    tpi_pkg::t_entry    r_cur, n_cur;
    logic               r_go, n_go;

    // arithmetic operands
    logic [31:0]        r_gap, n_gap;
    logic [31:0]        r_dt, n_dt;
    logic signed [31:0] r_base_y, n_base_y;
    logic signed [15:0] r_base_p, n_base_p;
    logic signed [32:0] r_diff_y, n_diff_y;
    logic signed [16:0] r_diff_p, n_diff_p;

    // result register
    logic [2:0]         r_status, n_status;
    logic signed [31:0] r_yaw, n_yaw;
    logic signed [15:0] r_pitch, n_pitch;

    // memory
    logic            w_we;
    tpi_pkg::t_idx   w_waddr, w_raddr;
    tpi_pkg::t_entry w_wdata, w_rdata;

    tpi_pkg::t_mdu_req w_req;
    tpi_pkg::t_mdu_rsp w_rsp;

    logic        w_in_acc, w_out_acc, w_full;
    logic [32:0] w_lead_hi, w_lag_lo, w_gap33;
    logic        w_cont, w_drop, w_gap_bad;
    tpi_pkg::t_entry w_base;

    logic [33:0]        w_yq;
    logic signed [34:0] w_ydelta, w_ysum;
    logic signed [31:0] w_ysat;
    logic signed [16:0] w_pneg;
    logic signed [15:0] w_psat;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;
    assign w_full    = (r_count == tpi_pkg::CNT_W'(tpi_pkg::HISTORY_DEPTH));

    // push goes into the oldest slot when full, else just past the newest
    assign w_we    = w_in_acc && (i_in.func == tpi_pkg::FUNC_PUSH);
    assign w_waddr = w_full ? r_oldest : r_oldest + r_count[tpi_pkg::IDX_W-1:0];
    assign w_wdata = '{stamp: i_in.stamp_us, yaw: i_in.yaw_in, pitch: i_in.pitch_in};
    assign w_raddr = (r_state == S_DRD) ? r_oldest : r_oldest + r_r;

    tpi_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tpi_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // operands for the shared unit follow the arithmetic step
    always_comb begin
        w_req.start   = r_go;
        w_req.divisor = r_gap;
        w_req.op      = tpi_pkg::OP_DIV;
        w_req.mul_a   = 34'(r_diff_y);
        w_req.mul_b   = r_dt;
        case (r_state)
            S_YMUL: begin
                w_req.op = tpi_pkg::OP_MUL_NEW;
            end
            S_PMUL0: begin
                // base pitch scaled by the gap
                w_req.op    = tpi_pkg::OP_MUL_NEW;
                w_req.mul_a = 34'(r_base_p);
                w_req.mul_b = r_gap;
            end
            S_PMUL1: begin
                w_req.op    = tpi_pkg::OP_MUL_ACC;
                w_req.mul_a = 34'(r_diff_p);
            end
            default: begin
                w_req.op = tpi_pkg::OP_DIV;
            end
        endcase
    end

    // yaw: quotient capped at 2^33, then added to the base and saturated
    always_comb begin
        w_yq     = (w_rsp.quo > 65'h2_0000_0000) ? 34'h2_0000_0000 : w_rsp.quo[33:0];
        w_ydelta = w_rsp.neg ? -$signed({1'b0, w_yq}) : $signed({1'b0, w_yq});
        w_ysum   = 35'(r_base_y) + w_ydelta;
        if (w_ysum > 35'sh0_7FFF_FFFF) begin
            w_ysat = 32'sh7FFF_FFFF;
        end else if (w_ysum < -35'sh0_8000_0000) begin
            w_ysat = -32'sh8000_0000;
        end else begin
            w_ysat = w_ysum[31:0];
        end
    end

    // pitch: sign-magnitude quotient saturated to 16 bits
    always_comb begin
        w_pneg = -$signed({1'b0, w_rsp.quo[15:0]});
        if (w_rsp.neg) begin
            w_psat = (w_rsp.quo > 65'd32768) ? -16'sd32768 : w_pneg[15:0];
        end else begin
            w_psat = (w_rsp.quo > 65'd32767) ? 16'sd32767 : w_rsp.quo[15:0];
        end
    end

    always_comb begin
        w_lead_hi = {1'b0, r_newest} + {1'b0, r_lead};
        w_lag_lo  = {1'b0, i_in.stamp_us} + {1'b0, r_lag};
        w_drop    = (w_rdata.stamp > r_t) || ((r_t - w_rdata.stamp) > r_window);
        // extrapolation takes the two newest entries; interpolation walks back
        // while the query time is not after the entry
        w_cont    = r_extrap ? r_first : (r_t <= w_rdata.stamp);
        w_gap33   = {1'b0, r_prev.stamp} - {1'b0, r_cur.stamp};
        w_gap_bad = r_extrap ? (w_gap33[32] || (w_gap33 == '0) || (w_gap33[31:0] > r_xgap))
                             : (w_gap33[31:0] > r_igap);
        w_base    = r_extrap ? r_prev : r_cur;
    end

    always_comb begin
        n_state  = r_state;
        n_oldest = r_oldest;
        n_count  = r_count;
        n_newest = r_newest;
        n_t      = r_t;
        n_extrap = r_extrap;
        n_latest = r_latest;
        n_first  = r_first;
        n_r      = r_r;
        n_prev   = r_prev;
        n_cur    = r_cur;
        n_go     = 1'b0;
        n_gap    = r_gap;
        n_dt     = r_dt;
        n_base_y = r_base_y;
        n_base_p = r_base_p;
        n_diff_y = r_diff_y;
        n_diff_p = r_diff_p;
        n_status = r_status;
        n_yaw    = r_yaw;
        n_pitch  = r_pitch;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_t      = i_in.stamp_us;
                    n_status = tpi_pkg::ST_OK;
                    n_yaw    = '0;
                    n_pitch  = '0;
                    n_first  = 1'b1;
                    n_r      = r_count[tpi_pkg::IDX_W-1:0] - 1'b1;
                    case (i_in.func)
                        tpi_pkg::FUNC_PUSH: begin
                            n_newest = i_in.stamp_us;
                            if (w_full) begin
                                n_oldest = r_oldest + 1'b1;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                            if (n_count > tpi_pkg::CNT_W'(1)) begin
                                n_state = S_DRD;
                            end
                        end
                        tpi_pkg::FUNC_QUERY: begin
                            n_latest = 1'b0;
                            n_extrap = ({1'b0, i_in.stamp_us} > {1'b0, r_newest});
                            if ((i_in.stamp_us == '0) || (r_count <= tpi_pkg::CNT_W'(2))) begin
                                n_status = tpi_pkg::ST_TOO_FEW;
                                n_state  = S_OUT;
                            end else if (({1'b0, i_in.stamp_us} > w_lead_hi) ||
                                         (w_lag_lo < {1'b0, r_newest})) begin
                                n_status = tpi_pkg::ST_RANGE;
                                n_state  = S_OUT;
                            end else begin
                                n_state = S_QRD;
                            end
                        end
                        tpi_pkg::FUNC_LATEST: begin
                            n_latest = 1'b1;
                            n_state  = (r_count == '0) ? S_OUT : S_QRD;
                        end
                        default: begin
                            // clear keeps the newest stamp
                            n_oldest = '0;
                            n_count  = '0;
                        end
                    endcase
                end
            end
            S_DRD: begin
                n_state = S_DCHK;
            end
            S_DCHK: begin
                n_state = S_IDLE;
                if (w_drop) begin
                    n_oldest = r_oldest + 1'b1;
                    n_count  = r_count - 1'b1;
                    if (n_count > tpi_pkg::CNT_W'(1)) begin
                        n_state = S_DRD;
                    end
                end
            end
            S_QRD: begin
                n_state = S_QCHK;
            end
            S_QCHK: begin
                if (r_latest) begin
                    n_yaw   = w_rdata.yaw;
                    n_pitch = w_rdata.pitch;
                    n_state = S_OUT;
                end else if (w_cont) begin
                    if (r_r == '0) begin
                        n_status = tpi_pkg::ST_BEFORE;
                        n_state  = S_OUT;
                    end else begin
                        n_prev  = w_rdata;
                        n_r     = r_r - 1'b1;
                        n_first = 1'b0;
                        n_state = S_QRD;
                    end
                end else begin
                    n_cur   = w_rdata;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_gap    = w_gap33[31:0];
                n_dt     = r_t - w_base.stamp;
                n_base_y = w_base.yaw;
                n_base_p = w_base.pitch;
                n_diff_y = 33'(r_prev.yaw) - 33'(r_cur.yaw);
                n_diff_p = 17'(r_prev.pitch) - 17'(r_cur.pitch);
                if (w_gap_bad) begin
                    n_status = r_extrap ? tpi_pkg::ST_EXTRAP_GAP : tpi_pkg::ST_INTERP_GAP;
                    n_state  = S_OUT;
                end else begin
                    n_go    = 1'b1;
                    n_state = S_YMUL;
                end
            end
            S_YMUL: begin
                if (w_rsp.done) begin
                    n_go    = 1'b1;
                    n_state = S_YDIV;
                end
            end
            S_YDIV: begin
                if (w_rsp.done) begin
                    n_yaw   = w_ysat;
                    n_go    = 1'b1;
                    n_state = S_PMUL0;
                end
            end
            S_PMUL0: begin
                if (w_rsp.done) begin
                    n_go    = 1'b1;
                    n_state = S_PMUL1;
                end
            end
            S_PMUL1: begin
                if (w_rsp.done) begin
                    n_go    = 1'b1;
                    n_state = S_PDIV;
                end
            end
            S_PDIV: begin
                if (w_rsp.done) begin
                    n_pitch = w_psat;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
            r_newest <= '0;
            r_go     <= 1'b0;
            r_window <= 32'd10000000;
            r_lead   <= 32'd80000;
            r_lag    <= 32'd500000;
            r_xgap   <= 32'd30000;
            r_igap   <= 32'd50000;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_newest <= n_newest;
            r_go     <= n_go;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    tpi_pkg::CFG_WINDOW: r_window <= i_cfg.data;
                    tpi_pkg::CFG_LEAD:   r_lead   <= i_cfg.data;
                    tpi_pkg::CFG_LAG:    r_lag    <= i_cfg.data;
                    tpi_pkg::CFG_XGAP:   r_xgap   <= i_cfg.data;
                    tpi_pkg::CFG_IGAP:   r_igap   <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_extrap <= n_extrap;
        r_latest <= n_latest;
        r_first  <= n_first;
        r_r      <= n_r;
        r_prev   <= n_prev;
        r_cur    <= n_cur;
        r_gap    <= n_gap;
        r_dt     <= n_dt;
        r_base_y <= n_base_y;
        r_base_p <= n_base_p;
        r_diff_y <= n_diff_y;
        r_diff_p <= n_diff_p;
        r_status <= n_status;
        r_yaw    <= n_yaw;
        r_pitch  <= n_pitch;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = (r_state == S_OUT);
    assign o_out.status    = r_status;
    assign o_out.yaw_out   = r_yaw;
    assign o_out.pitch_out = r_pitch;

`ifndef SYNTHESIS
    // never take a command while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("command taken while result pending");

    // ring fill never exceeds its depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tpi_pkg::CNT_W'(tpi_pkg::HISTORY_DEPTH))
        else $error("ring count overflow");

    // arithmetic completions only arrive while the sequencer waits on them
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_YMUL || r_state == S_YDIV || r_state == S_PMUL0 ||
                        r_state == S_PMUL1 || r_state == S_PDIV))
        else $error("unexpected arithmetic completion");

    // a delivered result frees the command channel next cycle
    a_free_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> i_in.ready)
        else $error("not ready after result beat");
`endif
endmodule

/* rtl/core/tpi_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_mem
// pose history storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module tpi_mem (
    input  logic            i_clk,
    input  logic            i_we,
    input  tpi_pkg::t_idx   i_waddr,
    input  tpi_pkg::t_entry i_wdata,
    input  tpi_pkg::t_idx   i_raddr,
    output tpi_pkg::t_entry o_rdata
);
    tpi_pkg::t_entry r_mem [tpi_pkg::HISTORY_DEPTH];
    tpi_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/tpi_mdu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpi_mdu
// shared serial multiply-accumulate and restoring divide, one bit per cycle
// ----------------------------------------------------------------------------
module tpi_mdu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpi_pkg::t_mdu_req i_req,
    output tpi_pkg::t_mdu_rsp o_rsp
);
    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_MUL  = 3'b010,
        M_DIV  = 3'b100
    } t_mstate;

    t_mstate                             r_state, n_state;
    logic [tpi_pkg::STEP_W-1:0]          r_cnt, n_cnt;
    logic                                r_done, n_done;
    logic signed [tpi_pkg::ACC_W-1:0]    r_acc, n_acc;
    logic signed [tpi_pkg::ACC_W-1:0]    r_a, n_a;
    logic [31:0]                         r_b, n_b;
    logic [tpi_pkg::QUO_W-1:0]           r_quo, n_quo;
    logic [31:0]                         r_rem, n_rem;
    logic [31:0]                         r_dvs, n_dvs;
    logic                                r_neg, n_neg;

    logic [32:0]                      w_trial;
    logic [32:0]                      w_diff;
    logic                             w_ge;
    logic signed [tpi_pkg::ACC_W-1:0] w_mag;

    always_comb begin
        w_trial = {r_rem, r_quo[tpi_pkg::QUO_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        w_mag   = r_acc[tpi_pkg::ACC_W-1] ? -r_acc : r_acc;

        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_acc   = r_acc;
        n_a     = r_a;
        n_b     = r_b;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_neg   = r_neg;
        case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == tpi_pkg::OP_DIV) begin
                        n_state = M_DIV;
                        n_cnt   = tpi_pkg::STEP_W'(tpi_pkg::QUO_W - 1);
                        n_neg   = r_acc[tpi_pkg::ACC_W-1];
                        n_quo   = w_mag[tpi_pkg::QUO_W-1:0];
                        n_rem   = '0;
                        n_dvs   = i_req.divisor;
                    end else begin
                        n_state = M_MUL;
                        n_cnt   = tpi_pkg::STEP_W'(tpi_pkg::MUL_STEPS - 1);
                        n_a     = tpi_pkg::ACC_W'(i_req.mul_a);
                        n_b     = i_req.mul_b;
                        if (i_req.op == tpi_pkg::OP_MUL_NEW) begin
                            n_acc = '0;
                        end
                    end
                end
            end
            M_MUL: begin
                n_acc = r_acc + (r_b[0] ? r_a : '0);
                n_a   = r_a <<< 1;
                n_b   = r_b >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = M_IDLE;
                    n_done  = 1'b1;
                end
            end
            M_DIV: begin
                n_rem = w_ge ? w_diff[31:0] : w_trial[31:0];
                n_quo = {r_quo[tpi_pkg::QUO_W-2:0], w_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = M_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.neg  = r_neg;
    assign o_rsp.quo  = r_quo;
endmodule
